// ===== hw/rtl/rau_pkg.sv =====
// shared types and constants of the rational arithmetic unit
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int MAG_W = 2 * WIDTH;

    typedef enum logic [2:0] {
        CMD_MAKE    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_EQUAL   = 3'd5,
        CMD_GREATER = 3'd6,
        CMD_LESS    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_ZERO_DEN = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    typedef struct packed {
        t_err                     err;
        logic                     cmp;
        logic [WIDTH-2:0]         den;
        logic signed [WIDTH-1:0]  num;
    } t_result;

endpackage

// ===== hw/rtl/rau_reduce.sv =====
// gcd reduction of a sign-magnitude fraction with overflow check
module rau_reduce (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_neg,
    input  logic [rau_pkg::MAG_W-1:0] i_nmag,
    input  logic [rau_pkg::MAG_W-1:0] i_dmag,
    output logic                  o_done,
    output rau_pkg::t_result      o_result
);
    import rau_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

    typedef enum logic [2:0] {
        R_IDLE, R_GCD, R_SHIFT, R_DIVN, R_DIVD
    } t_rstate;

    t_rstate           r_state;
    logic [MAG_W-1:0]  r_x, r_y, r_nmag, r_dmag, r_quo, r_nm;
    logic [MAG_W:0]    r_rem;
    logic [CNT_W-1:0]  r_sh, r_cnt;
    logic              r_neg, r_done;
    t_result           r_res;

    logic [MAG_W:0]    n_rem;
    logic [MAG_W-1:0]  n_quo;
    logic [MAG_W:0]    shifted;
    logic              neg_out, ovf;
    t_result           fin;

    always_comb begin
        shifted = {r_rem[MAG_W-1:0], r_quo[MAG_W-1]};
        if (shifted >= {1'b0, r_y}) begin
            n_rem = shifted - {1'b0, r_y};
            n_quo = {r_quo[MAG_W-2:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_quo = {r_quo[MAG_W-2:0], 1'b0};
        end
    end

    // final check uses the quotient of the denominator just formed
    always_comb begin
        neg_out = (r_nm != '0) && r_neg;
        ovf = (n_quo > LIM - 1) || (neg_out ? (r_nm > LIM) : (r_nm > LIM - 1));
        fin = '0;
        if (ovf) begin
            fin.err = ERR_OVERFLOW;
        end else begin
            fin.err = ERR_OK;
            fin.num = neg_out ? -r_nm[WIDTH-1:0] : r_nm[WIDTH-1:0];
            fin.den = n_quo[WIDTH-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == R_DIVD) && (r_cnt == CNT_W'(MAG_W - 1));
            case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_nmag;
                        r_y     <= i_dmag;
                        r_nmag  <= i_nmag;
                        r_dmag  <= i_dmag;
                        r_neg   <= i_neg;
                        r_sh    <= '0;
                        r_state <= R_GCD;
                    end
                end
                R_GCD: begin
                    if (r_x == '0) begin
                        r_state <= R_SHIFT;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x  <= r_x >> 1;
                        r_y  <= r_y >> 1;
                        r_sh <= r_sh + 1'b1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= r_x - r_y;
                    end else begin
                        r_y <= r_y - r_x;
                    end
                end
                R_SHIFT: begin
                    if (r_sh == '0) begin
                        r_quo   <= r_nmag;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= R_DIVN;
                    end else begin
                        r_y  <= r_y << 1;
                        r_sh <= r_sh - 1'b1;
                    end
                end
                R_DIVN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MAG_W - 1)) begin
                        r_nm    <= n_quo;
                        r_quo   <= r_dmag;
                        r_rem   <= '0;
                        r_state <= R_DIVD;
                    end else begin
                        r_quo <= n_quo;
                        r_rem <= n_rem;
                    end
                end
                R_DIVD: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    if (r_cnt == CNT_W'(MAG_W - 1)) begin
                        r_res   <= fin;
                        r_state <= R_IDLE;
                    end
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == R_IDLE) else $error("start while busy");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == R_GCD |-> r_y != '0) else $error("gcd divisor zero");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == R_IDLE && !$past(r_done)) else $error("done not a pulse");
`endif

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// rational arithmetic unit top level: operand capture, products, sequencing
// Usage: one item on the s_axis channel carries a command in tuser and four
// 32-bit signed operands in tdata; one result item leaves on m_axis.
// An item is taken when s_axis_tvalid and s_axis_tready are both high;
// s_axis_tready is high only while the unit is idle.
// Products are formed one per cycle on a shared 32x32 multiplier
// (two products, or three for add and sub), then the S_COMB state
// forms the fraction. Comparisons and zero denominators finish there.
// Arithmetic results go through a binary gcd (one shift or subtract per
// cycle), a shift-back of the common power of two and two 64-step
// restoring divisions on one shared divider.
// The result sits in an output register; the next item can be taken
// while it waits. If the receiver stalls with a result still held, the
// unit holds its finished result and stays busy until the register frees.
// Reset (synchronous, active low) returns to idle with no result pending.
module rational_arithmetic_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // a_num, a_den, b_num, b_den
    input  logic [2:0]   s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata    // res_num, res_den, cmp_true, error, zero pad
);
    import rau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_COMB, S_RED, S_OUT
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic signed [WIDTH-1:0]  r_an, r_ad, r_bn, r_bd;
    logic signed [MAG_W-1:0]  r_p0, r_p1, r_p2;
    logic [1:0]               r_k;
    logic                     r_m_valid;
    t_result                  r_m_res, r_res;
    logic                     r_red_start, r_red_neg;
    logic [MAG_W-1:0]         r_red_n, r_red_d;

    logic signed [WIDTH-1:0]  mul_a, mul_b;
    logic signed [MAG_W-1:0]  prod;
    logic [1:0]               last_k;
    logic signed [MAG_W+1:0]  sum, n_val, d_val;
    logic [MAG_W-1:0]         n_mag, d_mag;
    logic                     to_reduce;
    t_result                  n_res;
    logic                     red_done;
    t_result                  red_res;

    function automatic logic [MAG_W-1:0] f_abs(input logic signed [MAG_W+1:0] v);
        logic signed [MAG_W+1:0] t;
        t = (v < 0) ? -v : v;
        return t[MAG_W-1:0];
    endfunction

    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        case (r_k)
            2'd0: begin
                mul_a = r_an;
                case (r_cmd)
                    CMD_MAKE: mul_b = WIDTH'(1);
                    CMD_MUL:  mul_b = r_bn;
                    default:  mul_b = r_bd;
                endcase
            end
            2'd1: begin
                case (r_cmd)
                    CMD_MAKE: begin
                        mul_a = r_ad;
                        mul_b = WIDTH'(1);
                    end
                    CMD_MUL: begin
                        mul_a = r_ad;
                        mul_b = r_bd;
                    end
                    default: begin
                        mul_a = r_ad;
                        mul_b = r_bn;
                    end
                endcase
            end
            default: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
        endcase
        prod   = mul_a * mul_b;
        last_k = (r_cmd inside {CMD_ADD, CMD_SUB}) ? 2'd2 : 2'd1;
    end

    always_comb begin
        sum = (MAG_W+2)'(r_p0) + ((r_cmd == CMD_SUB) ? -(MAG_W+2)'(r_p1)
                                                    : (MAG_W+2)'(r_p1));
        if (r_cmd inside {CMD_ADD, CMD_SUB}) begin
            n_val = sum;
            d_val = (MAG_W+2)'(r_p2);
        end else begin
            n_val = (MAG_W+2)'(r_p0);
            d_val = (MAG_W+2)'(r_p1);
        end
        n_mag = f_abs(n_val);
        d_mag = f_abs(d_val);
        to_reduce = !(r_cmd inside {CMD_EQUAL, CMD_GREATER, CMD_LESS}) && (d_mag != '0);
    end

    // result formed directly when no reduction is needed
    always_comb begin
        n_res = '0;
        case (r_cmd)
            CMD_EQUAL:   n_res.cmp = (r_an == r_bn) && (r_ad == r_bd);
            CMD_GREATER: n_res.cmp = r_p0 > r_p1;
            CMD_LESS:    n_res.cmp = r_p0 < r_p1;
            default:     n_res.err = (d_mag == '0) ? ERR_ZERO_DEN : ERR_OK;
        endcase
    end

    rau_reduce u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_red_start),
        .i_neg    (r_red_neg),
        .i_nmag   (r_red_n),
        .i_dmag   (r_red_d),
        .o_done   (red_done),
        .o_result (red_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m_valid   <= 1'b0;
            r_red_start <= 1'b0;
        end else begin
            r_red_start <= (r_state == S_COMB) && to_reduce;
            if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
                r_m_res   <= r_res;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= t_cmd'(s_axis_tuser);
                        r_an    <= s_axis_tdata[31:0];
                        r_ad    <= s_axis_tdata[63:32];
                        r_bn    <= s_axis_tdata[95:64];
                        r_bd    <= s_axis_tdata[127:96];
                        r_k     <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_k)
                        2'd0:    r_p0 <= prod;
                        2'd1:    r_p1 <= prod;
                        default: r_p2 <= prod;
                    endcase
                    r_k <= r_k + 2'd1;
                    if (r_k == last_k) begin
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    r_res <= n_res;
                    if (to_reduce) begin
                        r_red_n   <= n_mag;
                        r_red_d   <= d_mag;
                        r_red_neg <= (n_val < 0) != (d_val < 0);
                        r_state   <= S_RED;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_RED: begin
                    if (red_done) begin
                        r_res   <= red_res;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_res};

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
    a_red_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RED && red_done |=> r_state == S_OUT) else $error("lost reduce result");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_res.err != ERR_OK |-> r_m_res.num == '0 && r_m_res.den == '0)
        else $error("error result not cleared");
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_res.cmp |-> r_m_res.err == ERR_OK && r_m_res.num == '0)
        else $error("compare result carries data");
`endif

endmodule
